FILE: rtl/core/ght_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle table package
// Shared sizes, payload structs, operation and status codes, and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ght_pkg;

  // Table geometry
  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);

  // Handle layout: generation | type | 32-bit index field
  localparam int unsigned GEN_W      = 16;
  localparam int unsigned TYPE_W     = 8;
  localparam int unsigned HIDX_W     = 32;
  localparam int unsigned HANDLE_W   = GEN_W + TYPE_W + HIDX_W;

  // Slot word: live bit | type | generation
  localparam int unsigned WORD_W     = 1 + TYPE_W + GEN_W;

  localparam logic [GEN_W-1:0] GEN_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [TYPE_W-1:0]   element_type;
    logic [HANDLE_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle_out;
    logic [1:0]          status;
    logic                error_sticky;
    logic [10:0]         live_count;
  } rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;  // request transfer, launch memory reads
    logic pop;     // read slot word at the popped index
    logic commit;  // update state and load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic pop_needed;  // incoming create will reuse a freed slot
    logic out_room;    // result register can take a new result
  } stat_t;

endpackage

FILE: rtl/core/generational_handle_table_top.sv
// Sequencing: after an input transfer the slot and stack memory reads are
//   registered, a create that reuses a freed slot adds a pop read, and the
//   result is registered at commit once the result register has room. One
//   request at a time; the result register lets the next one in while a result waits.
// Reset: counters, sticky flag and control clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// Generational handle table top level
// Hands out generation-tagged handles and checks them on delete and lookup.
// ----------------------------------------------------------------------------
module generational_handle_table_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ght_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ght_pkg::rsp_t out_data_o
);
  import ght_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ght_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ght_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // One request in flight: no transfer right after a transfer
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input transfer taken while a request is in flight");

  // A reusing create goes through the pop read
  a_pop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && stat.pop_needed) |=> cmd.pop)
    else $error("pop read skipped for a reusing create");

  // Commit only into a free result register
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> stat.out_room)
    else $error("result overwritten before transfer");

  // Live count never exceeds the table size
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.live_count <= 11'(SLOT_COUNT)))
    else $error("live count above slot count");

endmodule

FILE: rtl/core/ght_ctrl.sv
// ----------------------------------------------------------------------------
// Generational handle table controller
// Sequences one request at a time: accept, optional free-stack pop read,
// then commit once the result register has room.
// ----------------------------------------------------------------------------
module ght_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ght_pkg::stat_t stat_i,
  output ght_pkg::cmd_t  cmd_o
);
  import ght_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.pop_needed ? S_POP : S_EXEC;
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.out_room) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/ght_dp.sv
// ----------------------------------------------------------------------------
// Generational handle table datapath
// Slot word memory, free index stack, counters, request and result
// registers. Words read from slots at or above the append count are ignored, so
// the slot memory needs no clearing.
// ----------------------------------------------------------------------------
module ght_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ght_pkg::req_t  in_data_i,
  input  ght_pkg::cmd_t  cmd_i,
  output ght_pkg::stat_t stat_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ght_pkg::rsp_t  out_data_o
);
  import ght_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

  // Storage
  logic [WORD_W-1:0] slot_mem [SLOT_COUNT];
  logic [IDX_W-1:0]  stk_mem  [SLOT_COUNT];

  logic [WORD_W-1:0] slot_rd_q;
  logic [IDX_W-1:0]  stk_rd_q;

  logic [CNT_W-1:0]  in_use_q, depth_q, live_q;
  logic              failed_q;
  req_t              req_q;
  rsp_t              out_q;
  logic              out_valid_q;

  // Decode of the held request
  logic              have_pop, can_append, create_ok, match, del_ok, push;
  logic [IDX_W-1:0]  h_idx, c_idx, slot_raddr, slot_waddr;
  logic [GEN_W-1:0]  w_gen, c_gen;
  logic [TYPE_W-1:0] w_type;
  logic              w_live;
  logic              slot_we;
  logic [WORD_W-1:0] slot_wdata;
  logic [CNT_W-1:0]  live_d;
  logic              failed_d;
  rsp_t              rsp_d;

  assign {w_live, w_type, w_gen} = slot_rd_q;
  assign h_idx      = req_q.handle_in[IDX_W-1:0];
  assign have_pop   = (depth_q != '0);
  assign can_append = (in_use_q < FULL_CNT);
  assign c_idx      = have_pop ? stk_rd_q : in_use_q[IDX_W-1:0];
  assign c_gen      = have_pop ? (w_gen + GEN_W'(1)) : GEN_W'(1);

  // Handle match against the slot word read at accept time
  assign match = (req_q.handle_in[HIDX_W-1:IDX_W] == '0)
              && ({1'b0, h_idx} < in_use_q)
              && w_live
              && (w_type == req_q.handle_in[HIDX_W +: TYPE_W])
              && (w_gen == req_q.handle_in[HIDX_W+TYPE_W +: GEN_W]);

  assign create_ok = (req_q.operation == OP_CREATE) && (have_pop || can_append);
  assign del_ok    = (req_q.operation == OP_DELETE) && match;
  assign push      = del_ok && (w_gen != GEN_MAX) && (depth_q < FULL_CNT);

  // Result and next sticky / live values
  always_comb begin
    live_d   = live_q;
    failed_d = failed_q;
    rsp_d    = '0;
    rsp_d.status = ST_STALE;
    case (req_q.operation)
      OP_CREATE: begin
        if (create_ok) begin
          live_d           = live_q + CNT_W'(1);
          rsp_d.handle_out = {c_gen, req_q.element_type, HIDX_W'(c_idx)};
          rsp_d.status     = ST_OK;
        end else begin
          failed_d     = 1'b1;
          rsp_d.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (match) begin
          if (live_q != '0) live_d = live_q - CNT_W'(1);
          rsp_d.status = ST_OK;
        end else begin
          failed_d = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (match) rsp_d.status = ST_OK;
      end
      default: rsp_d.status = ST_STALE;
    endcase
    rsp_d.error_sticky = failed_d;
    rsp_d.live_count   = 11'(live_d);
  end

  // Slot memory port
  assign slot_raddr = cmd_i.pop ? stk_rd_q : in_data_i.handle_in[IDX_W-1:0];
  assign slot_we    = cmd_i.commit && (create_ok || del_ok);
  assign slot_waddr = (req_q.operation == OP_CREATE) ? c_idx : h_idx;
  assign slot_wdata = (req_q.operation == OP_CREATE)
                    ? {1'b1, req_q.element_type, c_gen}
                    : {1'b0, TYPE_W'(0), w_gen};

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (cmd_i.accept || cmd_i.pop) slot_rd_q <= slot_mem[slot_raddr];
  end

  // Free stack port: top entry read at accept, push on a good delete of a slot not at its last generation
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && push) stk_mem[depth_q[IDX_W-1:0]] <= h_idx;
    if (cmd_i.accept) stk_rd_q <= stk_mem[depth_q[IDX_W-1:0] - IDX_W'(1)];
  end

  // Request register
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) req_q <= in_data_i;
  end

  // Counters and sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      depth_q  <= '0;
      live_q   <= '0;
      failed_q <= 1'b0;
    end else if (cmd_i.commit) begin
      live_q   <= live_d;
      failed_q <= failed_d;
      if (create_ok && have_pop) depth_q <= depth_q - CNT_W'(1);
      else if (push)             depth_q <= depth_q + CNT_W'(1);
      if (create_ok && !have_pop) in_use_q <= in_use_q + CNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= rsp_d;
  end

  assign stat_o.pop_needed = (in_data_i.operation == OP_CREATE) && have_pop;
  assign stat_o.out_room   = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

FILE: bench/handle_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Handle table checker
// Watches both channels of the handle table. Each request transfer is run
// through a local copy of the slot table, free stack and counters, and the
// predicted response is queued. Each response transfer is compared field by
// field against the oldest queued prediction.
// ----------------------------------------------------------------------------
module handle_table_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  ght_pkg::req_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  ght_pkg::rsp_t  out_data_i,
  output int unsigned    mismatches_o,
  output int unsigned    outstanding_o
);
  import ght_pkg::*;

  // Shadow of the slot table: live bit, type and generation per slot
  logic              slot_live [SLOT_COUNT];
  logic [TYPE_W-1:0] slot_type [SLOT_COUNT];
  logic [GEN_W-1:0]  slot_gen  [SLOT_COUNT];
  logic [IDX_W-1:0]  free_idx  [SLOT_COUNT];
  int unsigned       appended;
  int unsigned       free_depth;
  int unsigned       live_total;
  logic              failed;

  rsp_t              expected_rsp [$];
  rsp_t              want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    if (mismatches_o < 40) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    end
    mismatches_o++;
  endtask

  // A handle names a live slot only if index, live bit, type and generation agree
  function automatic logic names_live_slot(input logic [HANDLE_W-1:0] h,
                                           output logic [IDX_W-1:0] idx);
    logic [HIDX_W-1:0] hidx;
    hidx = h[HIDX_W-1:0];
    idx  = hidx[IDX_W-1:0];
    if (hidx >= appended) return 1'b0;
    return slot_live[idx] &&
           (slot_type[idx] == h[HIDX_W +: TYPE_W]) &&
           (slot_gen[idx] == h[HIDX_W+TYPE_W +: GEN_W]);
  endfunction

  // Apply one request to the shadow table and build the response it yields
  function automatic rsp_t apply_request(input req_t r);
    rsp_t              res;
    logic [IDX_W-1:0]  idx;
    logic [HIDX_W-1:0] hidx;
    logic [GEN_W-1:0]  gen;
    logic              have;
    res        = '0;
    res.status = ST_STALE;
    idx        = '0;
    have       = 1'b1;
    case (r.operation)
      OP_CREATE: begin
        // most recently freed slot first, then a fresh one
        if (free_depth > 0) begin
          free_depth--;
          idx = free_idx[free_depth];
        end else if (appended < SLOT_COUNT) begin
          idx = appended[IDX_W-1:0];
          slot_gen[idx] = '0;
          appended++;
        end else begin
          have = 1'b0;
        end
        if (have) begin
          gen            = slot_gen[idx] + 1'b1;
          slot_live[idx] = 1'b1;
          slot_type[idx] = r.element_type;
          slot_gen[idx]  = gen;
          live_total++;
          hidx           = HIDX_W'(idx);
          res.handle_out = {gen, r.element_type, hidx};
          res.status     = ST_OK;
        end else begin
          res.status = ST_FULL;
          failed     = 1'b1;
        end
      end
      OP_DELETE: begin
        if (names_live_slot(r.handle_in, idx)) begin
          slot_live[idx] = 1'b0;
          slot_type[idx] = '0;
          if (live_total > 0) live_total--;
          // a slot at the last generation is retired, not recycled
          if (slot_gen[idx] != GEN_MAX && free_depth < SLOT_COUNT) begin
            free_idx[free_depth] = idx;
            free_depth++;
          end
          res.status = ST_OK;
        end else begin
          failed = 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (names_live_slot(r.handle_in, idx)) res.status = ST_OK;
      end
      default: ;
    endcase
    res.error_sticky = failed;
    res.live_count   = live_total[10:0];
    return res;
  endfunction

  // Compare response transfers first, then queue the prediction for a request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_live[i] = 1'b0;
        slot_type[i] = '0;
        slot_gen[i]  = '0;
        free_idx[i]  = '0;
      end
      appended   = 0;
      free_depth = 0;
      live_total = 0;
      failed     = 1'b0;
      expected_rsp.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("response with nothing outstanding",
                          64'(out_data_i.handle_out), '0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data_i.handle_out !== want.handle_out)
            report_mismatch("handle_out", 64'(out_data_i.handle_out),
                            64'(want.handle_out));
          if (out_data_i.status !== want.status)
            report_mismatch("status", 64'(out_data_i.status), 64'(want.status));
          if (out_data_i.error_sticky !== want.error_sticky)
            report_mismatch("error_sticky", 64'(out_data_i.error_sticky),
                            64'(want.error_sticky));
          if (out_data_i.live_count !== want.live_count)
            report_mismatch("live_count", 64'(out_data_i.live_count),
                            64'(want.live_count));
        end
      end
      if (in_valid_i && in_ready_i) expected_rsp.push_back(apply_request(in_data_i));
      outstanding_o = expected_rsp.size();
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generational handle table testbench
// Drives create, delete and lookup requests with bursty valid and a stalling
// receiver: a directed opener, a table fill past full, a random mix, a run
// that frees and reissues one slot over and over, and a tail after that.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
  import ght_pkg::*;

  localparam logic [1:0]  OP_UNDEFINED = 2'd3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MIXED_ITEMS  = 120;
  localparam int unsigned REUSE_PAIRS  = 24;
  localparam int unsigned TAIL_ITEMS   = 40;

  typedef enum int unsigned {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_BURSTY,
    RDY_SCARCE
  } ready_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  int unsigned mismatches;
  int unsigned outstanding;

  // Handles known live from responses, and handles known dead
  logic [HANDLE_W-1:0] live_pool [$];
  logic [HANDLE_W-1:0] dead_pool [$];
  logic [HANDLE_W-1:0] last_created;
  bit                  collect = 1'b0;
  bit                  fast    = 1'b0;

  int unsigned n_sent      = 0;
  int unsigned n_created   = 0;
  int unsigned n_full      = 0;
  int unsigned n_stale     = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned reuse_pairs = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;

  generational_handle_table_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  handle_table_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Harvest returned handles for later deletes and lookups
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (out_data.status == ST_OK && out_data.handle_out != '0) begin
        last_created = out_data.handle_out;
        n_created++;
        if (collect) live_pool.push_back(out_data.handle_out);
      end
      if (out_data.status == ST_FULL) n_full++;
      if (out_data.status == ST_STALE) n_stale++;
    end
  end

  // Receiver: switches between random stall patterns; always ready in fast mode
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(3));
      mode_left  = $urandom_range(512, 64);
    end
    mode_left--;
    if (fast) begin
      out_ready = 1'b1;
    end else begin
      case (ready_mode)
        RDY_ALWAYS: out_ready = 1'b1;
        RDY_RANDOM: out_ready = ($urandom_range(3) != 0);
        RDY_BURSTY: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready = 1'b0;
          end else begin
            out_ready = 1'b1;
            if ($urandom_range(7) == 0) stall_left = $urandom_range(30, 1);
          end
        end
        default: out_ready = ($urandom_range(3) == 0);
      endcase
    end
  end

  function automatic logic [HANDLE_W-1:0] make_handle(input logic [GEN_W-1:0] g,
                                                      input logic [TYPE_W-1:0] t,
                                                      input logic [HIDX_W-1:0] i);
    return {g, t, i};
  endfunction

  function automatic logic [HANDLE_W-1:0] random_handle();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[HANDLE_W-1:0];
  endfunction

  // A handle that should not match: a live one with one field broken, a dead one, or junk
  function automatic logic [HANDLE_W-1:0] broken_handle();
    logic [HANDLE_W-1:0] h;
    logic [31:0]         hi;
    int unsigned         b;
    if (live_pool.size() == 0) return random_handle();
    h = live_pool[$urandom_range(live_pool.size() - 1)];
    case ($urandom_range(4))
      0: h = random_handle();
      1: begin
        b = HIDX_W + $urandom_range(TYPE_W - 1);
        h[b] = ~h[b];
      end
      2: begin
        b = HIDX_W + TYPE_W + $urandom_range(GEN_W - 1);
        h[b] = ~h[b];
      end
      3: begin
        // index field with bits above the table size set
        hi = $urandom();
        if (hi[HIDX_W-IDX_W-1:0] == '0) hi = 32'd1;
        h[HIDX_W-1:IDX_W] = hi[HIDX_W-IDX_W-1:0];
      end
      default: begin
        if (dead_pool.size() > 0) h = dead_pool[$urandom_range(dead_pool.size() - 1)];
        else h = random_handle();
      end
    endcase
    return h;
  endfunction

  // One request transfer; valid drops after acceptance, gaps come between bursts
  task automatic send(input logic [1:0] op, input logic [TYPE_W-1:0] etype,
                      input logic [HANDLE_W-1:0] h);
    int unsigned gap;
    if (!fast) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 1);
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(8, 1);
        repeat (gap) @(negedge clk_i);
      end
      burst_left--;
    end
    in_data.operation    = op;
    in_data.element_type = etype;
    in_data.handle_in    = h;
    in_valid = 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
    n_sent++;
  endtask

  task automatic wait_idle();
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // Random request: creates, deletes and lookups in the given shares, rare undefined codes
  task automatic random_item(input int unsigned create_pct, input int unsigned delete_pct);
    int unsigned         roll;
    int unsigned         pick;
    logic [HANDLE_W-1:0] h;
    roll = $urandom_range(99);
    if (roll < create_pct) begin
      send(OP_CREATE, TYPE_W'($urandom_range(255)), random_handle());
    end else if (roll < create_pct + delete_pct) begin
      if (live_pool.size() > 0 && $urandom_range(99) < 85) begin
        pick = $urandom_range(live_pool.size() - 1);
        h = live_pool[pick];
        live_pool[pick] = live_pool[$];
        void'(live_pool.pop_back());
        dead_pool.push_back(h);
        if (dead_pool.size() > 64) void'(dead_pool.pop_front());
      end else begin
        h = broken_handle();
      end
      send(OP_DELETE, TYPE_W'($urandom_range(255)), h);
    end else if (roll < 97) begin
      if (live_pool.size() > 0 && $urandom_range(99) < 60)
        h = live_pool[$urandom_range(live_pool.size() - 1)];
      else
        h = broken_handle();
      send(OP_LOOKUP, TYPE_W'($urandom_range(255)), h);
    end else begin
      send(OP_UNDEFINED, TYPE_W'($urandom_range(255)), random_handle());
    end
  endtask

  initial begin
    logic [HANDLE_W-1:0] h;
    logic [TYPE_W-1:0]   etype;
    int unsigned         full_goal;
    rst_ni  = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opener: misses and the undefined code first, sticky still clear
    send(OP_LOOKUP, 8'h00, '1);
    send(OP_UNDEFINED, 8'hff, '1);
    send(OP_CREATE, 8'h00, '0);
    send(OP_CREATE, 8'hff, '1);
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'h00, 32'd0));
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'hff, 32'd1));
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'hfe, 32'd1));
    send(OP_LOOKUP, 8'h00, make_handle(16'd2, 8'hff, 32'd1));
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'hff, 32'h8000_0001));
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'h00, 32'd2));
    send(OP_DELETE, 8'h00, make_handle(16'd1, 8'h00, 32'd0));
    send(OP_LOOKUP, 8'h00, make_handle(16'd1, 8'h00, 32'd0));
    // double delete is stale and sets the sticky flag
    send(OP_DELETE, 8'h00, make_handle(16'd1, 8'h00, 32'd0));
    send(OP_CREATE, 8'h5a, '0);
    send(OP_LOOKUP, 8'h00, make_handle(16'd2, 8'h5a, 32'd0));
    send(OP_DELETE, 8'hff, '1);
    send(OP_DELETE, 8'h00, make_handle(16'd1, 8'hff, 32'd1));
    send(OP_CREATE, 8'h81, '0);
    send(OP_LOOKUP, 8'h00, '0);
    send(OP_UNDEFINED, 8'h00, '0);
    wait_idle();
    live_pool.push_back(make_handle(16'd2, 8'h5a, 32'd0));
    live_pool.push_back(make_handle(16'd2, 8'h81, 32'd1));
    collect = 1'b1;

    // Fill the table until creates are refused a few times
    full_goal = n_full + 6;
    for (int i = 0; i < 3000 && n_full < full_goal; i++) random_item(92, 2);

    // Mixed stretch, freeing slots for reuse
    for (int i = 0; i < MIXED_ITEMS; i++) random_item(35, 40);
    wait_idle();

    // Free and reissue one slot repeatedly through the free stack
    if (live_pool.size() > 0) begin
      h = live_pool.pop_back();
      send(OP_DELETE, 8'h00, h);
    end
    collect = 1'b0;
    etype = TYPE_W'($urandom_range(255));
    send(OP_CREATE, etype, '0);
    wait_idle();
    fast = 1'b1;
    h = last_created;
    for (int i = 0; i < REUSE_PAIRS; i++) begin
      send(OP_DELETE, etype, h);
      send(OP_CREATE, etype, h);
      h[HANDLE_W-1 -: GEN_W] = h[HANDLE_W-1 -: GEN_W] + 1'b1;
      reuse_pairs++;
    end
    send(OP_DELETE, etype, h);
    fast = 1'b0;
    send(OP_LOOKUP, etype, h);
    send(OP_DELETE, etype, h);
    collect = 1'b1;

    // Tail after the reuse run
    for (int i = 0; i < TAIL_ITEMS; i++) random_item(45, 35);

    wait_idle();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d requests: %0d handles created, %0d creates refused as full, %0d stale.",
             n_sent, n_created, n_full, n_stale);
    $display("One slot was freed and handed out again %0d times in a row.",
             reuse_pairs);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
